>>> src/bmp24_to_rgb565_stream_assert.svh
// Assertion macros for the decoder top level.
// They expect clk and rst to be in scope at the point of use.
`ifndef BMP24_TO_RGB565_STREAM_ASSERT_SVH
`define BMP24_TO_RGB565_STREAM_ASSERT_SVH

// Consequent checked at the same edge as the antecedent.
`define B2R_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define B2R_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/b2r_pkg.sv
package b2r_pkg;

  // result kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X      = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y      = 2'd1;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd2;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

  localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd240;
  localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd320;

  // header byte positions at which a field is complete
  localparam logic [5:0] HDR_SIGNATURE   = 6'd1;
  localparam logic [5:0] HDR_OFFSET      = 6'd13;
  localparam logic [5:0] HDR_WIDTH       = 6'd21;
  localparam logic [5:0] HDR_HEIGHT      = 6'd25;
  localparam logic [5:0] HDR_PLANES      = 6'd27;
  localparam logic [5:0] HDR_DEPTH       = 6'd29;
  localparam logic [5:0] HDR_COMPRESSION = 6'd33;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_PLANES    = 16'd1;
  localparam logic [15:0] BMP_DEPTH     = 16'd24;
  localparam logic [31:0] HEADER_LEN    = 32'd34;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [11:0]        screen_width;
    logic [11:0]        screen_height;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic signed [17:0] pixel_x;
    logic signed [17:0] pixel_y;
    logic [15:0]        color;
    logic               visible;
    logic               last;
  } result_t;

endpackage

>>> src/b2r_parser.sv
module b2r_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      file_byte,
  input  logic            restart,
  input  b2r_pkg::cfg_t   cfg,
  output b2r_pkg::result_t res
);

  typedef enum logic [2:0] {
    MODE_HEADER,
    MODE_SKIP,
    MODE_PIXEL,
    MODE_PAD,
    MODE_DONE
  } mode_t;

  mode_t       mode, mode_next;
  logic [5:0]  header_index, header_index_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] data_offset, data_offset_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [15:0] row_count, row_count_next;
  logic [15:0] column_count, column_count_next;
  logic [1:0]  component_phase, component_phase_next;
  logic [7:0]  held_blue, held_blue_next;
  logic [7:0]  held_green, held_green_next;
  logic [1:0]  pad_remaining, pad_remaining_next;

  // state as seen by this byte: a restart byte starts from a clean parser
  mode_t       cur_mode;
  logic [5:0]  cur_index;
  logic [31:0] cur_shift, cur_position, cur_offset;
  logic [15:0] cur_width, cur_height, cur_row, cur_column;
  logic [1:0]  cur_phase, cur_pad;
  logic [7:0]  cur_blue, cur_green;

  logic [31:0] shift_in;
  logic [15:0] column_inc, row_inc;
  logic [17:0] px, py;
  logic        vis;

  always_comb begin
    cur_mode     = restart ? MODE_HEADER : mode;
    cur_index    = restart ? '0 : header_index;
    cur_shift    = restart ? '0 : field_shift;
    cur_position = restart ? '0 : byte_position;
    cur_offset   = restart ? '0 : data_offset;
    cur_width    = restart ? '0 : image_width;
    cur_height   = restart ? '0 : image_height;
    cur_row      = restart ? '0 : row_count;
    cur_column   = restart ? '0 : column_count;
    cur_phase    = restart ? '0 : component_phase;
    cur_pad      = restart ? '0 : pad_remaining;
    cur_blue     = restart ? '0 : held_blue;
    cur_green    = restart ? '0 : held_green;
  end

  assign shift_in   = {file_byte, cur_shift[31:8]};
  assign column_inc = cur_column + 16'd1;
  assign row_inc    = cur_row + 16'd1;
  assign px = {{2{cfg.origin_x[15]}}, cfg.origin_x} + {2'b00, cur_column};
  assign py = {{2{cfg.origin_y[15]}}, cfg.origin_y} + {2'b00, cur_height}
              - 18'd1 - {2'b00, cur_row};
  assign vis = !px[17] && (px[16:0] < {5'd0, cfg.screen_width})
            && !py[17] && (py[16:0] < {5'd0, cfg.screen_height});

  always_comb begin
    mode_next            = cur_mode;
    header_index_next    = cur_index;
    field_shift_next     = cur_shift;
    byte_position_next   = cur_position;
    data_offset_next     = cur_offset;
    image_width_next     = cur_width;
    image_height_next    = cur_height;
    row_count_next       = cur_row;
    column_count_next    = cur_column;
    component_phase_next = cur_phase;
    held_blue_next       = cur_blue;
    held_green_next      = cur_green;
    pad_remaining_next   = cur_pad;
    res                  = '0;

    case (cur_mode)
      MODE_HEADER: begin
        field_shift_next   = shift_in;
        byte_position_next = {26'd0, cur_index} + 32'd1;
        header_index_next  = cur_index + 6'd1;
        case (cur_index)
          b2r_pkg::HDR_SIGNATURE: begin
            if (shift_in[31:16] != b2r_pkg::BMP_SIGNATURE) begin
              res.valid = 1'b1;
              res.kind  = b2r_pkg::KIND_ERROR;
            end
          end
          b2r_pkg::HDR_OFFSET: data_offset_next  = shift_in;
          b2r_pkg::HDR_WIDTH:  image_width_next  = shift_in[15:0];
          b2r_pkg::HDR_HEIGHT: image_height_next = shift_in[15:0];
          b2r_pkg::HDR_PLANES: begin
            if (shift_in[31:16] != b2r_pkg::BMP_PLANES) begin
              res.valid = 1'b1;
              res.kind  = b2r_pkg::KIND_ERROR;
            end
          end
          b2r_pkg::HDR_DEPTH: begin
            if (shift_in[31:16] != b2r_pkg::BMP_DEPTH) begin
              res.valid = 1'b1;
              res.kind  = b2r_pkg::KIND_ERROR;
            end
          end
          b2r_pkg::HDR_COMPRESSION: begin
            if (shift_in != '0) begin
              res.valid = 1'b1;
              res.kind  = b2r_pkg::KIND_ERROR;
            end else if (cur_width == '0 || cur_height == '0) begin
              res.valid = 1'b1;
              res.kind  = b2r_pkg::KIND_EMPTY;
            end else if (cur_offset <= b2r_pkg::HEADER_LEN) begin
              mode_next = MODE_PIXEL;
            end else begin
              mode_next = MODE_SKIP;
            end
          end
          default: ;
        endcase
        if (res.valid) begin
          res.last  = 1'b1;
          mode_next = MODE_DONE;
        end
      end
      MODE_SKIP: begin
        byte_position_next = cur_position + 32'd1;
        if (byte_position_next >= cur_offset) mode_next = MODE_PIXEL;
      end
      MODE_PIXEL: begin
        case (cur_phase)
          2'd0: begin
            held_blue_next       = file_byte;
            component_phase_next = 2'd1;
          end
          2'd1: begin
            held_green_next      = file_byte;
            component_phase_next = 2'd2;
          end
          default: begin
            component_phase_next = 2'd0;
            res.valid   = 1'b1;
            res.kind    = b2r_pkg::KIND_PIXEL;
            res.pixel_x = px;
            res.pixel_y = py;
            res.color   = {file_byte[7:3], cur_green[7:2], cur_blue[7:3]};
            res.visible = vis;
            if (column_inc >= cur_width) begin
              column_count_next = '0;
              row_count_next    = row_inc;
              if (row_inc >= cur_height) begin
                res.last  = 1'b1;
                mode_next = MODE_DONE;
              end else if (cur_width[1:0] != 2'd0) begin
                // row padding equals width mod 4 for three-byte pixels
                pad_remaining_next = cur_width[1:0];
                mode_next          = MODE_PAD;
              end
            end else begin
              column_count_next = column_inc;
            end
          end
        endcase
      end
      MODE_PAD: begin
        pad_remaining_next = cur_pad - 2'd1;
        if (pad_remaining_next == 2'd0) mode_next = MODE_PIXEL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_HEADER;
      header_index    <= '0;
      field_shift     <= '0;
      byte_position   <= '0;
      data_offset     <= '0;
      image_width     <= '0;
      image_height    <= '0;
      row_count       <= '0;
      column_count    <= '0;
      component_phase <= '0;
      held_blue       <= '0;
      held_green      <= '0;
      pad_remaining   <= '0;
    end else if (accept) begin
      mode            <= mode_next;
      header_index    <= header_index_next;
      field_shift     <= field_shift_next;
      byte_position   <= byte_position_next;
      data_offset     <= data_offset_next;
      image_width     <= image_width_next;
      image_height    <= image_height_next;
      row_count       <= row_count_next;
      column_count    <= column_count_next;
      component_phase <= component_phase_next;
      held_blue       <= held_blue_next;
      held_green      <= held_green_next;
      pad_remaining   <= pad_remaining_next;
    end
  end

endmodule

>>> src/bmp24_to_rgb565_stream.sv
// Output: the result of an accepted file byte is registered and appears on the master side in the next cycle.
// Throughput: one byte per cycle; the output register lets a new byte in
// while the previous result waits, as long as the master side takes it.
// Reset: synchronous rst clears the parser to header mode and sets origin to 0
// and screen size to 240 x 320; no clearing pass follows.
`include "bmp24_to_rgb565_stream_assert.svh"

module bmp24_to_rgb565_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [17:0] pixel_x, [35:18] pixel_y,
                                      // [51:36] color, [52] visible, zero above
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  b2r_pkg::cfg_t    cfg;
  b2r_pkg::result_t res;
  b2r_pkg::result_t out_res;
  logic             out_valid;
  logic             s_accept;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.screen_width  <= b2r_pkg::SCREEN_WIDTH_RESET;
      cfg.screen_height <= b2r_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        b2r_pkg::REG_ORIGIN_X:      cfg.origin_x      <= cfg_data;
        b2r_pkg::REG_ORIGIN_Y:      cfg.origin_y      <= cfg_data;
        b2r_pkg::REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[11:0];
        b2r_pkg::REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  b2r_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .file_byte (s_axis_tdata),
    .restart   (s_axis_tuser),
    .cfg       (cfg),
    .res       (res)
  );

  // output register: load a new result, otherwise drop the held one once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_accept && res.valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && res.valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.last;
  assign m_axis_tdata  = {3'b000, out_res.visible, out_res.color,
                          out_res.pixel_y, out_res.pixel_x};

  `B2R_ASSERT_NOW(a_status_clean,
    out_valid && out_res.kind != b2r_pkg::KIND_PIXEL,
    out_res.last && m_axis_tdata == '0,
    "status transaction carries pixel data or lacks last")

  `B2R_ASSERT_NOW(a_visible_on_screen,
    out_valid && out_res.visible,
    !out_res.pixel_x[17] && !out_res.pixel_y[17],
    "visible pixel at negative coordinate")

  `B2R_ASSERT_NOW(a_ready_when_empty,
    !out_valid,
    s_axis_tready,
    "input stalled while output register is empty")

  `B2R_ASSERT_NEXT(a_result_lands,
    s_accept && res.valid,
    m_axis_tvalid,
    "result of an accepted byte lost")

endmodule

>>> tb/bmp_pixel_checker.sv
`timescale 1ns / 1ps

module bmp_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [2:0] {
    HEADER_MODE,
    SKIP_MODE,
    PIXEL_MODE,
    PAD_MODE,
    DONE_MODE
  } parse_mode_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [17:0] pixel_x;
    logic signed [17:0] pixel_y;
    logic [15:0]        color;
    logic               visible;
    logic               last;
  } pixel_res_t;

  pixel_res_t decoded_q[$];

  logic signed [15:0] org_x, org_y;
  logic [11:0]        scr_w, scr_h;

  parse_mode_t mode;
  logic [5:0]  hdr_idx;
  logic [31:0] hdr_shift, byte_pos, pix_offset;
  logic [15:0] img_w, img_h, row_cnt, col_cnt;
  logic [1:0]  comp_phase, pad_left;
  logic [7:0]  blue_byte, green_byte;

  initial fail_count = 0;

  task automatic restart_parse();
    mode = HEADER_MODE;
    hdr_idx = '0;
    hdr_shift = '0;
    byte_pos = '0;
    pix_offset = '0;
    img_w = '0;
    img_h = '0;
    row_cnt = '0;
    col_cnt = '0;
    comp_phase = '0;
    blue_byte = '0;
    green_byte = '0;
    pad_left = '0;
  endtask

  task automatic post_status(input logic [1:0] kind);
    pixel_res_t r;
    r = '0;
    r.kind = kind;
    r.last = 1'b1;
    decoded_q.push_back(r);
    mode = DONE_MODE;
  endtask

  task automatic take_header_byte(input logic [7:0] b);
    logic [5:0] idx;
    idx = hdr_idx;
    hdr_shift = {b, hdr_shift[31:8]};
    byte_pos = 32'(idx) + 32'd1;
    hdr_idx = idx + 6'd1;
    case (idx)
      b2r_pkg::HDR_SIGNATURE:
        if (hdr_shift[31:16] != b2r_pkg::BMP_SIGNATURE) post_status(b2r_pkg::KIND_ERROR);
      b2r_pkg::HDR_OFFSET: pix_offset = hdr_shift;
      b2r_pkg::HDR_WIDTH:  img_w = hdr_shift[15:0];
      b2r_pkg::HDR_HEIGHT: img_h = hdr_shift[15:0];
      b2r_pkg::HDR_PLANES:
        if (hdr_shift[31:16] != b2r_pkg::BMP_PLANES) post_status(b2r_pkg::KIND_ERROR);
      b2r_pkg::HDR_DEPTH:
        if (hdr_shift[31:16] != b2r_pkg::BMP_DEPTH) post_status(b2r_pkg::KIND_ERROR);
      b2r_pkg::HDR_COMPRESSION: begin
        if (hdr_shift != '0) post_status(b2r_pkg::KIND_ERROR);
        else if (img_w == '0 || img_h == '0) post_status(b2r_pkg::KIND_EMPTY);
        else mode = (pix_offset <= b2r_pkg::HEADER_LEN) ? PIXEL_MODE : SKIP_MODE;
      end
      default: ;
    endcase
  endtask

  task automatic take_pixel_byte(input logic [7:0] b);
    pixel_res_t r;
    longint     px, py;
    logic [1:0] pad;
    if (comp_phase == 2'd0) begin
      blue_byte = b;
      comp_phase = 2'd1;
    end else if (comp_phase == 2'd1) begin
      green_byte = b;
      comp_phase = 2'd2;
    end else begin
      comp_phase = 2'd0;
      px = longint'(org_x) + longint'(col_cnt);
      py = longint'(org_y) + longint'(img_h) - 1 - longint'(row_cnt);
      r.kind = b2r_pkg::KIND_PIXEL;
      r.pixel_x = px[17:0];
      r.pixel_y = py[17:0];
      r.color = {b[7:3], green_byte[7:2], blue_byte[7:3]};
      r.visible = (px >= 0) && (px < longint'(scr_w))
               && (py >= 0) && (py < longint'(scr_h));
      r.last = 1'b0;
      col_cnt = col_cnt + 16'd1;
      if (col_cnt >= img_w) begin
        col_cnt = '0;
        row_cnt = row_cnt + 16'd1;
        // rows are rounded up to whole 32-bit words
        pad = 2'd0 - 2'(img_w * 16'd3);
        if (row_cnt >= img_h) begin
          r.last = 1'b1;
          mode = DONE_MODE;
        end else if (pad != 2'd0) begin
          pad_left = pad;
          mode = PAD_MODE;
        end
      end
      decoded_q.push_back(r);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic restart);
    if (restart) restart_parse();
    case (mode)
      HEADER_MODE: take_header_byte(b);
      SKIP_MODE: begin
        byte_pos = byte_pos + 32'd1;
        if (byte_pos >= pix_offset) mode = PIXEL_MODE;
      end
      PIXEL_MODE: take_pixel_byte(b);
      PAD_MODE: begin
        pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) mode = PIXEL_MODE;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    pixel_res_t want, got;
    got.kind = m_axis_tuser;
    got.pixel_x = m_axis_tdata[17:0];
    got.pixel_y = m_axis_tdata[35:18];
    got.color = m_axis_tdata[51:36];
    got.visible = m_axis_tdata[52];
    got.last = m_axis_tlast;
    if (decoded_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t: unexpected result, expected none, %s %0d x %0d y %0d %s %h %s %0d %s %0d",
                 $time, "actual kind", got.kind, got.pixel_x, got.pixel_y, "color",
                 got.color, "vis", got.visible, "last", got.last);
    end else begin
      want = decoded_q.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("pixel_x", want.pixel_x, got.pixel_x);
      check_field("pixel_y", want.pixel_y, got.pixel_y);
      check_field("color", want.color, got.color);
      check_field("visible", want.visible, got.visible);
      check_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      org_x = '0;
      org_y = '0;
      scr_w = b2r_pkg::SCREEN_WIDTH_RESET;
      scr_h = b2r_pkg::SCREEN_HEIGHT_RESET;
      restart_parse();
      decoded_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          b2r_pkg::REG_ORIGIN_X:      org_x = cfg_data;
          b2r_pkg::REG_ORIGIN_Y:      org_y = cfg_data;
          b2r_pkg::REG_SCREEN_WIDTH:  scr_w = cfg_data[11:0];
          b2r_pkg::REG_SCREEN_HEIGHT: scr_h = cfg_data[11:0];
          default: ;
        endcase
      end
      // compare before predicting: a result never leaves in the cycle its byte enters
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser);
    end
    pending = decoded_q.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ITEM_TARGET    = 1850;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = b2r_pkg::REG_ORIGIN_X;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int useful_bytes = 0;
  int rand_base = 0;

  // {restart, file byte}
  logic [8:0] file_q[$];

  bmp24_to_rgb565_stream u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  bmp_pixel_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= restart;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // hold the sender until every result in flight has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_config(input logic [15:0] ox, input logic [15:0] oy,
                              input logic [15:0] sw, input logic [15:0] sh);
    cfg_we <= 1'b1;
    cfg_index <= b2r_pkg::REG_ORIGIN_X;
    cfg_data <= ox;
    @(posedge clk);
    cfg_index <= b2r_pkg::REG_ORIGIN_Y;
    cfg_data <= oy;
    @(posedge clk);
    cfg_index <= b2r_pkg::REG_SCREEN_WIDTH;
    cfg_data <= sw;
    @(posedge clk);
    cfg_index <= b2r_pkg::REG_SCREEN_HEIGHT;
    cfg_data <= sh;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b);
    file_q.push_back({1'b0, b});
    useful_bytes++;
  endtask

  // bytes the parser drops once a file is over
  task automatic push_trail(input int n);
    repeat (n) file_q.push_back({1'b0, 8'($urandom)});
  endtask

  task automatic push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) push_byte(v[8*i +: 8]);
  endtask

  task automatic push_header(input logic [15:0] sig, input logic [31:0] offset,
                             input logic [31:0] w32, input logic [31:0] h32,
                             input logic [15:0] planes, input logic [15:0] depth,
                             input logic [31:0] comp);
    push_le({16'd0, sig}, 2);
    push_le($urandom, 4);
    push_le($urandom, 4);
    push_le(offset, 4);
    push_le($urandom, 4);
    push_le(w32, 4);
    push_le(h32, 4);
    push_le({16'd0, planes}, 2);
    push_le({16'd0, depth}, 2);
    push_le(comp, 4);
  endtask

  task automatic push_body(input longint w, input longint h, input logic [31:0] offset,
                           input int max_px);
    longint npx;
    int     pad;
    if (offset > b2r_pkg::HEADER_LEN)
      repeat (offset - b2r_pkg::HEADER_LEN) push_byte(8'($urandom));
    npx = w * h;
    if (npx > longint'(max_px)) npx = longint'(max_px);
    pad = int'((4 - (w * 3) % 4) % 4);
    for (longint i = 0; i < npx; i++) begin
      repeat (3) push_byte(8'($urandom));
      if ((i + 1) % w == 0 && i + 1 < w * h) repeat (pad) push_byte(8'($urandom));
    end
  endtask

  task automatic good_file(input logic [31:0] w32, input logic [31:0] h32,
                           input logic [31:0] offset, input int max_px);
    push_header(b2r_pkg::BMP_SIGNATURE, offset, w32, h32, b2r_pkg::BMP_PLANES,
                b2r_pkg::BMP_DEPTH, '0);
    push_body(longint'(w32[15:0]), longint'(h32[15:0]), offset, max_px);
  endtask

  task automatic send_file(input logic first_restart, input int pause_at);
    for (int i = 0; i < file_q.size(); i++) begin
      if (i == pause_at) drain();
      send_byte(file_q[i][7:0], file_q[i][8] | (i == 0 && first_restart));
    end
    file_q.delete();
  endtask

  task automatic rand_file();
    int          sel, w, h, n;
    logic [31:0] offset, w32, h32, comp;
    logic [15:0] sig, planes, depth;
    logic        first_restart;
    sel = $urandom_range(99);
    first_restart = 1'b1;
    offset = ($urandom_range(2) == 0) ? 32'($urandom_range(34)) : 32'(34 + $urandom_range(1, 24));
    w = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
    h = $urandom_range(1, 6);
    w32 = ($urandom_range(3) == 0) ? {16'($urandom), 16'(w)} : 32'(w);
    h32 = ($urandom_range(3) == 0) ? {16'($urandom), 16'(h)} : 32'(h);
    if (sel < 66) begin
      // mostly whole images, now and then cut short by the next restart
      good_file(w32, h32, offset, ($urandom_range(7) == 0) ? $urandom_range(0, w * h) : w * h);
      if ($urandom_range(3) == 0) push_trail($urandom_range(1, 6));
    end else if (sel < 74) begin
      if ($urandom_range(1)) begin
        w32 = 32'($urandom_range(1, 4));
        h32 = 32'($urandom_range(1000, 65535));
      end else begin
        w32 = 32'($urandom_range(1000, 65535));
        h32 = 32'($urandom_range(1, 65535));
      end
      good_file(w32, h32, offset, $urandom_range(1, 12));
    end else if (sel < 84) begin
      sig = b2r_pkg::BMP_SIGNATURE;
      planes = b2r_pkg::BMP_PLANES;
      depth = b2r_pkg::BMP_DEPTH;
      comp = '0;
      case ($urandom_range(3))
        0: sig = sig ^ 16'($urandom_range(1, 65535));
        1: planes = planes ^ 16'($urandom_range(1, 65535));
        2: depth = depth ^ 16'($urandom_range(1, 65535));
        default: comp = $urandom | (32'd1 << $urandom_range(31));
      endcase
      push_header(sig, offset, w32, h32, planes, depth, comp);
      push_trail($urandom_range(0, 8));
    end else if (sel < 90) begin
      if ($urandom_range(1)) w32[15:0] = '0;
      else h32[15:0] = '0;
      push_header(b2r_pkg::BMP_SIGNATURE, offset, w32, h32, b2r_pkg::BMP_PLANES,
                  b2r_pkg::BMP_DEPTH, '0);
      push_trail($urandom_range(0, 6));
    end else begin
      // raw noise with the odd restart in the middle
      n = $urandom_range(1, 40);
      repeat (n) file_q.push_back({$urandom_range(15) == 0, 8'($urandom)});
      first_restart = 1'($urandom);
    end
    send_file(first_restart,
              ($urandom_range(24) == 0) ? $urandom_range(0, file_q.size() - 1) : -1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset configuration
    send_idle_pct = 26;
    recv_stall_pct = 26;

    // first file after reset, no restart flag; white then black pixel, then dropped bytes
    push_header(b2r_pkg::BMP_SIGNATURE, 32'd34, 32'd2, 32'd1, b2r_pkg::BMP_PLANES,
                b2r_pkg::BMP_DEPTH, '0);
    repeat (3) push_byte(8'hFF);
    repeat (3) push_byte(8'h00);
    push_trail(3);
    send_file(1'b0, -1);

    // gap before pixel data, then one, two, three and no pad bytes per row
    good_file(32'd1, 32'd3, 32'd54, 100);
    send_file(1'b1, -1);
    good_file(32'd2, 32'd2, 32'd0, 100);
    send_file(1'b1, -1);
    good_file(32'd3, 32'd2, 32'd1, 100);
    send_file(1'b1, -1);
    good_file(32'd4, 32'd2, 32'd35, 100);
    send_file(1'b1, -1);

    // header faults; only the first is reported
    push_header(16'h4D43, 32'd34, 32'd2, 32'd2, b2r_pkg::BMP_PLANES, b2r_pkg::BMP_DEPTH, '0);
    send_file(1'b1, -1);
    push_header(16'hCD42, 32'd34, 32'd2, 32'd2, 16'd0, b2r_pkg::BMP_DEPTH, '0);
    send_file(1'b1, -1);
    push_header(b2r_pkg::BMP_SIGNATURE, 32'd34, 32'd2, 32'd2, 16'd2, 16'd8, '0);
    send_file(1'b1, -1);
    push_header(b2r_pkg::BMP_SIGNATURE, 32'd34, 32'd2, 32'd2, b2r_pkg::BMP_PLANES,
                16'd32, '0);
    send_file(1'b1, -1);
    push_header(b2r_pkg::BMP_SIGNATURE, 32'd34, 32'd2, 32'd2, b2r_pkg::BMP_PLANES,
                b2r_pkg::BMP_DEPTH, 32'd1);
    push_trail(4);
    send_file(1'b1, -1);
    push_header(b2r_pkg::BMP_SIGNATURE, 32'd34, 32'd2, 32'd2, b2r_pkg::BMP_PLANES,
                b2r_pkg::BMP_DEPTH, 32'h8000_0000);
    send_file(1'b1, -1);

    // empty images, including a width whose low half is zero, then a height whose upper half is ignored
    push_header(b2r_pkg::BMP_SIGNATURE, 32'd34, 32'd0, 32'd5, b2r_pkg::BMP_PLANES,
                b2r_pkg::BMP_DEPTH, '0);
    send_file(1'b1, -1);
    push_header(b2r_pkg::BMP_SIGNATURE, 32'd34, 32'd3, 32'd0, b2r_pkg::BMP_PLANES,
                b2r_pkg::BMP_DEPTH, '0);
    send_file(1'b1, -1);
    push_header(b2r_pkg::BMP_SIGNATURE, 32'd34, 32'h0001_0000, 32'd1, b2r_pkg::BMP_PLANES,
                b2r_pkg::BMP_DEPTH, '0);
    send_file(1'b1, -1);
    good_file(32'd2, 32'h0001_0002, 32'd34, 100);
    send_file(1'b1, -1);

    // restart in the middle of pixel data, then the tallest and widest images cut short
    good_file(32'd5, 32'd4, 32'd34, 7);
    send_file(1'b1, -1);
    good_file(32'd3, 32'd65535, 32'd34, 6);
    send_file(1'b1, -1);
    good_file(32'd65535, 32'd2, 32'd34, 5);
    send_file(1'b1, -1);

    // sender held mid-image until the output side is empty
    good_file(32'd4, 32'd3, 32'd40, 100);
    send_file(1'b1, 50);

    // share what is left of the byte budget between the phases
    rand_base = useful_bytes;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: apply_config(16'h8000, 16'h8000, {4'($urandom), 12'd4095}, {4'($urandom), 12'd4095});
        1: apply_config(16'h7FFF, 16'h7FFF, {4'($urandom), 12'd1}, {4'($urandom), 12'd1});
        2: apply_config(16'd0, 16'd0, 16'd1, 16'd1);
        3: apply_config(-16'sd3, -16'sd2, 16'd5, 16'd4);
        4: apply_config(16'd0, 16'd0, {4'($urandom), 12'd0}, {4'($urandom), 12'd0});
        5: apply_config(-16'sd1, -16'sd1, 16'd4095, 16'd4095);
        6: apply_config(16'($urandom_range(16)) - 16'd8, 16'($urandom_range(16)) - 16'd8,
                        16'($urandom_range(1, 10)), 16'($urandom_range(1, 10)));
        default: apply_config(16'd0, 16'd0, {4'd0, b2r_pkg::SCREEN_WIDTH_RESET},
                              {4'd0, b2r_pkg::SCREEN_HEIGHT_RESET});
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 46;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 46;
        end
        default: begin
          send_idle_pct = 26;
          recv_stall_pct = 26;
        end
      endcase
      do begin
        rand_file();
      end while (useful_bytes < rand_base + (ITEM_TARGET - rand_base) * (p + 1) / PHASES);
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
